>>> sv/double_ended_queue_unit_assert.svh
// Assertion macros for the deque unit; empty bodies for synthesis.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on clk, skipped while rst_n is low.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on clk at every edge, reset included.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DEQ_ASSERT(lbl, prop, msg)
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> sv/deq_pkg.sv
// Shared constants and request/status codes for the deque unit.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 16;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;
  localparam int TOTAL_W   = 5;

  // Value shown at both ends when the deque is empty
  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REVERSE    = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SORT       = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

>>> sv/deq_store.sv
// Ring store of the deque: one write port, one registered read port.
`timescale 1ns / 1ps

module deq_store import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [IW-1:0]            wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [IW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/deq_cmp.sv
// Shared signed comparator: does a belong after b in physical order.
`timescale 1ns / 1ps

module deq_cmp import deq_pkg::*; (
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  input  logic                     desc,
  output logic                     after
);

  // Ascending order normally, descending in physical order when reversed
  assign after = desc ? (a < b) : (a > b);

endmodule

>>> sv/double_ended_queue_unit.sv
// Deque unit top level: request sequencer, end readout and result register.
// A request is taken only while the unit is idle. Push, pop, clear, reverse
// and the unused code go through these steps: the transfer in (update the
// pointers and write on push), read the first slot, read the last slot, and
// load the result register; the unit turns idle for the next request as
// that register is loaded. Both end values come through the single read
// port of the store. Sort runs an insertion sort over that same port with
// one shared comparator: for each key after the first it reads the key,
// latches it and reads its left neighbor, shifts each neighbor that belongs
// after the key into the hole, then writes the key into the hole, and it
// ends with the same readout steps. A finished result waits in the output
// register while out_stall is high. The next request is still taken and
// worked through, then waits in its last step until the register is free.
// No further request is taken meanwhile.
`timescale 1ns / 1ps

module double_ended_queue_unit import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [REQ_W-1:0]          in_req_type,
  input  logic signed [DATA_W-1:0]  in_push_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  out_front_value,
  output logic signed [DATA_W-1:0]  out_back_value,
  output logic [TOTAL_W-1:0]        out_entry_total,
  output logic                      out_is_empty,
  output logic [STAT_W-1:0]         out_status
);

`include "double_ended_queue_unit_assert.svh"

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD_FIRST = 3'd1;
  localparam logic [2:0] S_RD_LAST  = 3'd2;
  localparam logic [2:0] S_FIN      = 3'd3;
  localparam logic [2:0] S_KEY_RD   = 3'd4;
  localparam logic [2:0] S_KEY      = 3'd5;
  localparam logic [2:0] S_CMP      = 3'd6;
  localparam logic [2:0] S_PUT      = 3'd7;

  // Step a physical slot back by one around the ring
  function automatic logic [IW-1:0] slot_dec(input logic [IW-1:0] p);
    logic [IW-1:0] r;
    if (p == '0) r = IW'(DEPTH - 1);
    else         r = p - IW'(1);
    return r;
  endfunction

  // Step a physical slot forward by one around the ring
  function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] p);
    logic [IW-1:0] r;
    if (p == IW'(DEPTH - 1)) r = '0;
    else                     r = p + IW'(1);
    return r;
  endfunction

  // Control state
  logic [2:0]      state_r, state_nxt;
  logic [IW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            rev_r, rev_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Sort walk
  logic [IW-1:0]   i_r, i_nxt;
  logic [IW-1:0]   j_r, j_nxt;
  logic [IW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic signed [DATA_W-1:0] first_r, first_nxt;

  // Result register
  logic signed [DATA_W-1:0] front_r, front_nxt;
  logic signed [DATA_W-1:0] back_r, back_nxt;
  logic [TOTAL_W-1:0]       total_r, total_nxt;
  logic                     empty_r, empty_nxt;
  logic [STAT_W-1:0]        ostat_r, ostat_nxt;

  // Store port and shared units
  logic                     st_we, st_re;
  logic [IW-1:0]            st_waddr, st_raddr;
  logic signed [DATA_W-1:0] st_wdata, st_rdata;
  logic [IW-1:0]            off;
  logic [IW:0]              slot_sum;
  logic [IW-1:0]            slot;
  logic                     after;
  logic                     phys_front;
  logic                     out_free;
  logic [31:0]              count_ext;

  deq_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_en   (st_re),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  deq_cmp u_cmp (
    .a     (st_rdata),
    .b     (key_r),
    .desc  (rev_r),
    .after (after)
  );

  // Logical offset to physical slot, wrapping once around the ring
  always_comb begin
    unique case (state_r)
      S_IDLE:    off = IW'(count_r);
      S_RD_LAST: off = IW'(count_r - CW'(1));
      default:   off = i_r;
    endcase
    slot_sum = {1'b0, head_r} + {1'b0, off};
    if (slot_sum >= (IW + 1)'(DEPTH)) slot = IW'(slot_sum - (IW + 1)'(DEPTH));
    else                               slot = IW'(slot_sum);
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  assign phys_front = (in_req_type == REQ_PUSH_FRONT || in_req_type == REQ_POP_FRONT) ^ rev_r;
  assign count_ext  = 32'(count_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    key_nxt       = key_r;
    first_nxt     = first_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    total_nxt     = total_r;
    empty_nxt     = empty_r;
    ostat_nxt     = ostat_r;
    st_we         = 1'b0;
    st_waddr      = wr_ptr_r;
    st_wdata      = key_r;
    st_re         = 1'b0;
    st_raddr      = rd_ptr_r;

    // result leaves on a transfer out
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_DONE;
          state_nxt  = S_RD_FIRST;
          unique case (in_req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              if (count_r >= CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                st_we     = 1'b1;
                st_wdata  = in_push_value;
                count_nxt = count_r + CW'(1);
                if (phys_front) begin
                  head_nxt = slot_dec(head_r);
                  st_waddr = slot_dec(head_r);
                end else begin
                  st_waddr = slot;
                end
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
                if (phys_front) head_nxt = slot_inc(head_r);
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
              head_nxt  = '0;
              rev_nxt   = 1'b0;
            end
            REQ_REVERSE: begin
              if (count_r != '0) rev_nxt = !rev_r;
            end
            REQ_SORT: begin
              if (count_r >= CW'(2)) begin
                i_nxt     = IW'(1);
                state_nxt = S_KEY_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_FIRST: begin
        st_re     = 1'b1;
        st_raddr  = head_r;
        state_nxt = S_RD_LAST;
      end
      S_RD_LAST: begin
        first_nxt = st_rdata;
        st_re     = 1'b1;
        st_raddr  = slot;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          if (count_r == '0) begin
            front_nxt = EMPTY_VALUE;
            back_nxt  = EMPTY_VALUE;
          end else if (rev_r) begin
            front_nxt = st_rdata;
            back_nxt  = first_r;
          end else begin
            front_nxt = first_r;
            back_nxt  = st_rdata;
          end
          total_nxt     = count_ext[TOTAL_W-1:0];
          empty_nxt     = (count_r == '0);
          ostat_nxt     = status_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      // fetch key i, hole starts at its slot
      S_KEY_RD: begin
        st_re      = 1'b1;
        st_raddr   = slot;
        wr_ptr_nxt = slot;
        rd_ptr_nxt = slot_dec(slot);
        state_nxt  = S_KEY;
      end
      S_KEY: begin
        key_nxt   = st_rdata;
        j_nxt     = i_r;
        st_re     = 1'b1;
        st_raddr  = rd_ptr_r;
        state_nxt = S_CMP;
      end
      // shift the left neighbor into the hole while it belongs after the key
      S_CMP: begin
        if (after) begin
          st_we      = 1'b1;
          st_waddr   = wr_ptr_r;
          st_wdata   = st_rdata;
          j_nxt      = j_r - IW'(1);
          wr_ptr_nxt = rd_ptr_r;
          rd_ptr_nxt = slot_dec(rd_ptr_r);
          if (j_r > IW'(1)) begin
            st_re    = 1'b1;
            st_raddr = slot_dec(rd_ptr_r);
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        st_we    = 1'b1;
        st_waddr = wr_ptr_r;
        st_wdata = key_r;
        i_nxt    = i_r + IW'(1);
        if (CW'(i_r) + CW'(1) < count_r) state_nxt = S_KEY_RD;
        else                             state_nxt = S_RD_FIRST;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      status_r    <= ST_DONE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wr_ptr_r <= wr_ptr_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    key_r    <= key_nxt;
    first_r  <= first_nxt;
    front_r  <= front_nxt;
    back_r   <= back_nxt;
    total_r  <= total_nxt;
    empty_r  <= empty_nxt;
    ostat_r  <= ostat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;
  assign out_entry_total = total_r;
  assign out_is_empty    = empty_r;
  assign out_status      = ostat_r;

  // Checks
  `DEQ_ASSERT(a_count_bound, (count_r <= CW'(DEPTH)), "entry count above depth")
  `DEQ_ASSERT(a_busy_after_take, (in_valid && !in_stall) |=> in_stall, "idle after a transfer in")
  `DEQ_ASSERT(a_sort_count_hold, (state_r >= S_KEY_RD) |=> $stable(count_r), "count moved in sort")
  `DEQ_ASSERT(a_sort_walk_bound, (state_r == S_CMP) |-> (CW'(j_r) < count_r), "sort walk out of range")
endmodule
